// File: rtl/core/kmdne_pkg.sv
// Shared constants for the key matrix debounce and note event unit.
package kmdne_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_DEBOUNCE_COUNT = 3'd0;
  localparam logic [2:0] REG_NOTE_BASE      = 3'd1;
  localparam logic [2:0] REG_MIDI_CHANNEL   = 3'd2;
  localparam logic [2:0] REG_PRESS_VELOCITY = 3'd3;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 7;

  // Reset values of the configuration registers
  localparam logic [3:0] DEBOUNCE_COUNT_RST = 4'd3;
  localparam logic [6:0] NOTE_BASE_RST      = 7'd60;
  localparam logic [3:0] MIDI_CHANNEL_RST   = 4'd0;
  localparam logic [6:0] PRESS_VELOCITY_RST = 7'd127;

  // Note-on status byte with channel zero
  localparam logic [7:0] STATUS_NOTE_ON = 8'h90;

  // Width of the row level field
  localparam int unsigned ROW_LEVELS_W = 5;

endpackage

// File: rtl/core/key_matrix_debounce_note_events_unit.sv
// Key matrix debouncer: per-key counters walked row by row, note message emitter.
// Flow: a scan transfer is followed by a debounce update of every row key of the current column, one row key a
// cycle through a shared counter and compare; emitting then walks the rows again and can be held
// by output stalls. A new scan is stalled until emitting has finished. Reset: configuration to
// defaults, keys released, column 0.
module key_matrix_debounce_note_events_unit #(
  parameter int unsigned ROW_COUNT    = 5,
  parameter int unsigned COLUMN_COUNT = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Scan input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [kmdne_pkg::ROW_LEVELS_W-1:0]  row_levels_i,
  // Note message output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          status_byte_o,
  output logic [6:0]                          note_number_o,
  output logic [6:0]                          velocity_byte_o,
  output logic [3:0]                          key_index_o,
  output logic                                last_event_o,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [kmdne_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [kmdne_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned KEY_TOTAL = ROW_COUNT * COLUMN_COUNT;
  localparam int unsigned KW  = (KEY_TOTAL > 1) ? $clog2(KEY_TOTAL) : 1;
  localparam int unsigned KXW = (KW > 7) ? KW : 7;
  localparam int unsigned RW  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int unsigned CW  = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
  localparam int unsigned LVW = (ROW_COUNT > kmdne_pkg::ROW_LEVELS_W) ?
                                ROW_COUNT : kmdne_pkg::ROW_LEVELS_W;

  localparam logic [RW-1:0] ROW_LAST = RW'(ROW_COUNT - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMN_COUNT - 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [RW-1:0]        row_q, row_d;
  logic [CW-1:0]        col_q, col_d;
  logic [LVW-1:0]       levels_q, levels_d;
  logic [ROW_COUNT-1:0] mask_q, mask_d;

  // Configuration registers
  logic [3:0] debounce_count_q;
  logic [6:0] note_base_q;
  logic [3:0] midi_channel_q;
  logic [6:0] press_velocity_q;

  // Per-key state
  logic           pend_q [KEY_TOTAL];
  logic [4:0]     cnt_q  [KEY_TOTAL];
  logic           down_q [KEY_TOTAL];

  // Output register
  logic       out_valid_q;
  logic [7:0] status_q;
  logic [6:0] note_q;
  logic [6:0] vel_q;
  logic [3:0] key_q;
  logic       last_q;

  logic           in_xfer;
  logic           out_free;
  logic           out_load;
  logic [KXW-1:0] key_full;
  logic [KW-1:0]  key_addr;
  logic           level;
  logic           pend_cur;
  logic [4:0]     cnt_cur;
  logic           down_cur;
  logic [4:0]     thresh;
  logic [4:0]     thresh_p1;
  logic [4:0]     cnt_inc;
  logic           scan_we;
  logic           pend_nx;
  logic [4:0]     cnt_nx;
  logic           down_we;
  logic           mask_set;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Shared key address: current column, current row
  assign key_full = KXW'(col_q) * KXW'(ROW_COUNT) + KXW'(row_q);
  assign key_addr = key_full[KW-1:0];
  assign level    = levels_q[row_q];
  assign pend_cur = pend_q[key_addr];
  assign cnt_cur  = cnt_q[key_addr];
  assign down_cur = down_q[key_addr];

  // Debounce threshold, a zero count behaves as one
  assign thresh    = (debounce_count_q == 4'd0) ? 5'd1 : {1'b0, debounce_count_q};
  assign thresh_p1 = thresh + 5'd1;
  assign cnt_inc   = cnt_cur + 5'd1;

  // Debounce update of the addressed key
  always_comb begin
    pend_nx  = pend_cur;
    cnt_nx   = cnt_cur;
    down_we  = 1'b0;
    mask_set = 1'b0;
    if (level != pend_cur) begin
      pend_nx = level;
      cnt_nx  = 5'd0;
    end else if (cnt_cur >= thresh_p1) begin
      cnt_nx = thresh_p1;
    end else if (cnt_inc == thresh) begin
      cnt_nx = thresh_p1;
      if (down_cur != pend_cur) begin
        down_we  = 1'b1;
        mask_set = 1'b1;
      end
    end else begin
      cnt_nx = cnt_inc;
    end
  end

  assign scan_we  = (state_q == ST_SCAN);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_EMIT) && (mask_q != '0) && mask_q[row_q] && out_free;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    row_d    = row_q;
    col_d    = col_q;
    levels_d = levels_q;
    mask_d   = mask_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          levels_d = LVW'(row_levels_i);
          mask_d   = '0;
          row_d    = '0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (mask_set) begin
          mask_d[row_q] = 1'b1;
        end
        if (row_q == ROW_LAST) begin
          row_d   = '0;
          state_d = ST_EMIT;
        end else begin
          row_d = row_q + RW'(1);
        end
      end
      ST_EMIT: begin
        if (mask_q == '0) begin
          // Advance to the next column
          col_d   = (col_q == COL_LAST) ? '0 : col_q + CW'(1);
          state_d = ST_IDLE;
        end else if (!mask_q[row_q]) begin
          row_d = row_q + RW'(1);
        end else if (out_free) begin
          mask_d[row_q] = 1'b0;
          if (row_q != ROW_LAST) begin
            row_d = row_q + RW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      mask_q  <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      mask_q  <= mask_d;
    end
  end

  // Hold the scanned row levels
  always_ff @(posedge clk_i) begin
    levels_q <= levels_d;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_count_q <= kmdne_pkg::DEBOUNCE_COUNT_RST;
      note_base_q      <= kmdne_pkg::NOTE_BASE_RST;
      midi_channel_q   <= kmdne_pkg::MIDI_CHANNEL_RST;
      press_velocity_q <= kmdne_pkg::PRESS_VELOCITY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        kmdne_pkg::REG_DEBOUNCE_COUNT: debounce_count_q <= cfg_data_i[3:0];
        kmdne_pkg::REG_NOTE_BASE:      note_base_q      <= cfg_data_i;
        kmdne_pkg::REG_MIDI_CHANNEL:   midi_channel_q   <= cfg_data_i[3:0];
        kmdne_pkg::REG_PRESS_VELOCITY: press_velocity_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Per-key debounce state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KEY_TOTAL; k++) begin
        pend_q[k] <= 1'b0;
        cnt_q[k]  <= 5'd0;
        down_q[k] <= 1'b0;
      end
    end else if (scan_we) begin
      pend_q[key_addr] <= pend_nx;
      cnt_q[key_addr]  <= cnt_nx;
      if (down_we) begin
        down_q[key_addr] <= pend_cur;
      end
    end
  end

  // Output valid: set on load, drop once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= kmdne_pkg::STATUS_NOTE_ON | {4'd0, midi_channel_q};
      note_q   <= note_base_q + key_full[6:0];
      vel_q    <= down_cur ? press_velocity_q : 7'd0;
      key_q    <= key_full[3:0];
      last_q   <= ((mask_q & ~(ROW_COUNT'(1) << row_q)) == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_byte_o   = status_q;
  assign note_number_o   = note_q;
  assign velocity_byte_o = vel_q;
  assign key_index_o     = key_q;
  assign last_event_o    = last_q;

endmodule

// File: dv/key_matrix_debounce_note_events_unit_tb.sv
// Self-checking testbench for the key matrix debounce and note event unit.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ROWS = 5;
  localparam int unsigned COLS = 2;
  localparam int unsigned KEYS = ROWS * COLS;

  // Indexes that decode to no register
  localparam logic [kmdne_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [kmdne_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  // Cycles to let pass after the last note message before touching registers
  localparam int unsigned SETTLE_CYCLES = 2 * (2 * ROWS + 2) + 6;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [3:0] key;
    logic       last;
  } note_msg_t;

  logic                               clk_i      = 1'b0;
  logic                               rst_ni     = 1'b0;
  logic                               in_valid   = 1'b0;
  logic                               in_stall;
  logic [kmdne_pkg::ROW_LEVELS_W-1:0] row_levels = '0;
  logic                               out_valid;
  logic                               out_stall  = 1'b0;
  logic [7:0]                         status_byte;
  logic [6:0]                         note_number;
  logic [6:0]                         velocity_byte;
  logic [3:0]                         key_index;
  logic                               last_event;
  logic                               cfg_valid  = 1'b0;
  logic                               cfg_ready;
  logic [kmdne_pkg::CFG_INDEX_W-1:0]  cfg_index  = '0;
  logic [kmdne_pkg::CFG_DATA_W-1:0]   cfg_data   = '0;

  key_matrix_debounce_note_events_unit #(
    .ROW_COUNT   (ROWS),
    .COLUMN_COUNT(COLS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .row_levels_i   (row_levels),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_byte_o  (status_byte),
    .note_number_o  (note_number),
    .velocity_byte_o(velocity_byte),
    .key_index_o    (key_index),
    .last_event_o   (last_event),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // Shadow of the block: configuration and per-key debounce state
  logic [3:0] shadow_debounce = kmdne_pkg::DEBOUNCE_COUNT_RST;
  logic [6:0] shadow_base     = kmdne_pkg::NOTE_BASE_RST;
  logic [3:0] shadow_channel  = kmdne_pkg::MIDI_CHANNEL_RST;
  logic [6:0] shadow_velocity = kmdne_pkg::PRESS_VELOCITY_RST;
  logic       key_pending [KEYS];
  logic [4:0] key_stable  [KEYS];
  logic       key_held    [KEYS];
  int unsigned scan_column = 0;

  logic [kmdne_pkg::ROW_LEVELS_W-1:0] scan_backlog[$];
  note_msg_t                          due_notes[$];
  int unsigned                        queued_column = 0;
  int                                 errors = 0;

  initial begin
    for (int k = 0; k < KEYS; k++) begin
      key_pending[k] = 1'b0;
      key_stable[k]  = '0;
      key_held[k]    = 1'b0;
    end
  end

  // Advance the debounce state by one column scan and queue the note messages it causes
  function automatic void predict_note_events(
    input logic [kmdne_pkg::ROW_LEVELS_W-1:0] rows);
    int unsigned limit;
    int unsigned key;
    int          n;
    note_msg_t   msgs[ROWS];
    limit = (shadow_debounce == 0) ? 1 : shadow_debounce;
    n = 0;
    for (int r = 0; r < ROWS; r++) begin
      key = scan_column * ROWS + r;
      if (rows[r] != key_pending[key]) begin
        key_pending[key] = rows[r];
        key_stable[key]  = '0;
      end else if (key_stable[key] >= limit + 1) begin
        key_stable[key] = 5'(limit + 1);
      end else begin
        key_stable[key] = key_stable[key] + 5'd1;
        if (key_stable[key] == limit) begin
          key_stable[key] = 5'(limit + 1);
          if (key_held[key] != key_pending[key]) begin
            key_held[key]    = key_pending[key];
            msgs[n].status   = kmdne_pkg::STATUS_NOTE_ON | {4'd0, shadow_channel};
            msgs[n].note     = shadow_base + 7'(key);
            msgs[n].velocity = key_held[key] ? shadow_velocity : 7'd0;
            msgs[n].key      = 4'(key);
            msgs[n].last     = 1'b0;
            n++;
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      msgs[i].last = (i == n - 1);
      due_notes.push_back(msgs[i]);
    end
    scan_column = (scan_column + 1) % COLS;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Scan driver: bursts of transfers separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      row_levels <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) predict_note_events(row_levels);
      // hold the payload while stalled
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (scan_backlog.size() != 0) begin
          in_valid   <= 1'b1;
          row_levels <= scan_backlog.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Note monitor: checks each transfer and stalls on a pattern that changes mode
  int        stall_mode  = 0;
  int        stall_timer = 0;
  int        stall_phase = 0;
  note_msg_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall   <= 1'b0;
      stall_mode  <= 0;
      stall_timer <= 0;
      stall_phase <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_notes.size() == 0) begin
          $display("%0t: unexpected note message, expected none actual status %0h note %0d",
                   $time, status_byte, note_number);
          errors++;
        end else begin
          want = due_notes.pop_front();
          check_field("status_byte", want.status, status_byte);
          check_field("note_number", {1'b0, want.note}, {1'b0, note_number});
          check_field("velocity_byte", {1'b0, want.velocity}, {1'b0, velocity_byte});
          check_field("key_index", {4'd0, want.key}, {4'd0, key_index});
          check_field("last_event", {7'd0, want.last}, {7'd0, last_event});
        end
      end
      // pick a new stall mode now and then
      if (stall_timer == 0) begin
        stall_mode  <= $urandom_range(0, 3);
        stall_timer <= $urandom_range(20, 80);
      end else begin
        stall_timer <= stall_timer - 1;
      end
      stall_phase <= (stall_phase + 1) % 3;
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_stall <= ($urandom_range(0, 7) == 0);
        end
        default: begin
          out_stall <= (stall_phase == 0);
        end
      endcase
    end
  end

  // Run limit
  int unsigned cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_scan(input logic [kmdne_pkg::ROW_LEVELS_W-1:0] rows);
    scan_backlog.push_back(rows);
    queued_column = (queued_column + 1) % COLS;
  endtask

  // Wait until every scan is taken and every note message is out, then let the block drain;
  // look between edges so that the driver's updates of this edge are already in place
  task automatic settle();
    while (scan_backlog.size() != 0 || in_valid || due_notes.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [kmdne_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [kmdne_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      kmdne_pkg::REG_DEBOUNCE_COUNT: shadow_debounce = data[3:0];
      kmdne_pkg::REG_NOTE_BASE:      shadow_base     = data[6:0];
      kmdne_pkg::REG_MIDI_CHANNEL:   shadow_channel  = data[3:0];
      kmdne_pkg::REG_PRESS_VELOCITY: shadow_velocity = data[6:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [6:0] debounce, input logic [6:0] base,
                           input logic [6:0] channel, input logic [6:0] velocity);
    write_reg(kmdne_pkg::REG_DEBOUNCE_COUNT, debounce);
    write_reg(kmdne_pkg::REG_NOTE_BASE, base);
    write_reg(kmdne_pkg::REG_MIDI_CHANNEL, channel);
    write_reg(kmdne_pkg::REG_PRESS_VELOCITY, velocity);
  endtask

  // Held chords per column, broken up by stray bit flips and bursts of noise
  task automatic queue_chords(input int count, input int hold_max);
    int                                 queued;
    int                                 hold;
    logic [kmdne_pkg::ROW_LEVELS_W-1:0] chord[COLS];
    logic [kmdne_pkg::ROW_LEVELS_W-1:0] rows;
    queued = 0;
    for (int c = 0; c < COLS; c++) chord[c] = 5'($urandom_range(0, 31));
    while (queued < count) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          queue_scan(5'($urandom_range(0, 31)));
          queued++;
        end
      end else begin
        for (int c = 0; c < COLS; c++) begin
          if ($urandom_range(0, 2) != 0) chord[c] = 5'($urandom_range(0, 31));
        end
        hold = $urandom_range(1, hold_max);
        repeat (hold * COLS) begin
          rows = chord[queued_column];
          if ($urandom_range(0, 11) == 0) rows[$urandom_range(0, ROWS - 1)] ^= 1'b1;
          queue_scan(rows);
          queued++;
        end
      end
    end
  endtask

  initial begin
    logic [6:0] debounce;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: press every key in both columns, then release them all
    repeat (4 * COLS) queue_scan(5'b11111);
    repeat (4 * COLS) queue_scan(5'b00000);
    settle();

    // Zero debounce count, wrapping note numbers, top channel, zero velocity
    configure(7'h70, 7'd127, 7'h7F, 7'd0);
    write_reg(REG_SPARE_HI, 7'h55);
    write_reg(REG_SPARE_LO, 7'h2A);
    repeat (2) begin
      queue_scan(5'b10101);
      queue_scan(5'b01010);
    end
    repeat (2) begin
      queue_scan(5'b01010);
      queue_scan(5'b10101);
    end
    settle();

    // Slowest debounce with long holds, so counters saturate
    configure(7'd15, 7'd0, 7'd5, 7'd1);
    queue_chords(50, 18);
    settle();

    // Drop to the fastest debounce while counters sit above it
    configure(7'd1, 7'd100, 7'd9, 7'd127);
    queue_chords(50, 4);
    settle();

    // Random settings
    repeat (4) begin
      debounce = 7'($urandom_range(0, 127));
      configure(debounce, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)));
      queue_chords(50, ((debounce[3:0] == 0) ? 1 : debounce[3:0]) + 3);
      settle();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/kmdne_pkg.sv
rtl/core/key_matrix_debounce_note_events_unit.sv
dv/key_matrix_debounce_note_events_unit_tb.sv
